// File: rtl/dsk_pkg.sv
// shared types and constants of the dual source key qualifier
package dsk_pkg;

  localparam int NumKeys = 18;
  localparam int BtnW = 18;
  localparam int AxisW = 16;
  localparam int TimerW = 8;
  localparam logic [TimerW-1:0] TimerMax = 8'hFF;
  localparam logic [TimerW-1:0] ThreshReset = 8'd6;

  typedef enum logic [1:0] {
    CmdTick       = 2'd0,
    CmdClrPress   = 2'd1,
    CmdClrRelease = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    LinkPrimary   = 2'd0,
    LinkSecondary = 2'd1,
    LinkLost      = 2'd2
  } link_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [4:0]              key_index;
    logic                    primary_up;
    logic                    secondary_up;
    logic signed [AxisW-1:0] primary_mouse_x;
    logic signed [AxisW-1:0] primary_mouse_y;
    logic signed [AxisW-1:0] primary_mouse_z;
    logic [BtnW-1:0]         primary_buttons;
    logic signed [AxisW-1:0] secondary_mouse_x;
    logic signed [AxisW-1:0] secondary_mouse_y;
    logic signed [AxisW-1:0] secondary_mouse_z;
    logic [BtnW-1:0]         secondary_buttons;
  } in_t;

  typedef struct packed {
    logic [1:0]              link_status;
    logic                    secondary_link_up;
    logic signed [AxisW-1:0] mouse_x;
    logic signed [AxisW-1:0] mouse_y;
    logic signed [AxisW-1:0] mouse_z;
    logic [BtnW-1:0]         pressed_keys;
    logic                    any_pressed;
    logic                    event_hit;
  } out_t;

  // merged view of both links for one tick
  typedef struct packed {
    logic [1:0]              status;
    logic                    sec_up;
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] z;
    logic [BtnW-1:0]         buttons;
  } merge_t;

  // per-key control from the top level
  typedef struct packed {
    logic tick;
    logic down;
    logic clr_press;
    logic clr_release;
  } lane_ctl_t;

  // per-key status back to the top level
  typedef struct packed {
    logic pressed_d;
    logic hit;
  } lane_sts_t;

endpackage

// File: rtl/dsk_link_merge.sv
// link selection and merge of mouse and button data from both links
module dsk_link_merge import dsk_pkg::*; (
  input  in_t    item_i,
  output merge_t merge_o
);

  function automatic logic signed [AxisW-1:0] pick_axis(
    input logic signed [AxisW-1:0] pv,
    input logic signed [AxisW-1:0] sv,
    input logic                    p_up
  );
    return (p_up || (pv != '0)) ? pv : sv;
  endfunction

  always_comb begin
    if (item_i.primary_up) begin
      merge_o.status = LinkPrimary;
    end else if (item_i.secondary_up) begin
      merge_o.status = LinkSecondary;
    end else begin
      merge_o.status = LinkLost;
    end
    merge_o.sec_up = item_i.secondary_up;
    merge_o.x = pick_axis(item_i.primary_mouse_x, item_i.secondary_mouse_x,
                          item_i.primary_up);
    merge_o.y = pick_axis(item_i.primary_mouse_y, item_i.secondary_mouse_y,
                          item_i.primary_up);
    merge_o.z = pick_axis(item_i.primary_mouse_z, item_i.secondary_mouse_z,
                          item_i.primary_up);
    // secondary buttons count only while the primary link is down
    merge_o.buttons = item_i.primary_up ? item_i.primary_buttons
                                        : (item_i.primary_buttons | item_i.secondary_buttons);
  end

endmodule

// File: rtl/dsk_key_lane.sv
// hold timer and sticky press and release events of one key
module dsk_key_lane import dsk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TimerW-1:0] threshold_i,
  input  lane_ctl_t         ctl_i,
  output lane_sts_t         sts_o
);

  logic [TimerW-1:0] timer_q, timer_d, timer_inc;
  logic              conf_q, conf_d;
  logic              press_q, press_d;
  logic              rel_q, rel_d;
  logic              pressed_q, pressed_d;

  assign timer_inc = (timer_q != TimerMax) ? timer_q + 1'b1 : timer_q;

  always_comb begin
    timer_d   = timer_q;
    conf_d    = conf_q;
    press_d   = press_q;
    rel_d     = rel_q;
    pressed_d = pressed_q;
    if (ctl_i.tick) begin
      pressed_d = ctl_i.down;
      if (ctl_i.down) begin
        timer_d = timer_inc;
        if (timer_inc == threshold_i) begin
          press_d = 1'b1;
          conf_d  = 1'b1;
        end
      end else begin
        timer_d = '0;
        if (conf_q) begin
          rel_d  = 1'b1;
          conf_d = 1'b0;
        end
      end
    end
    if (ctl_i.clr_press) begin
      press_d = 1'b0;
    end
    if (ctl_i.clr_release) begin
      rel_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q   <= '0;
      conf_q    <= 1'b0;
      press_q   <= 1'b0;
      rel_q     <= 1'b0;
      pressed_q <= 1'b0;
    end else begin
      timer_q   <= timer_d;
      conf_q    <= conf_d;
      press_q   <= press_d;
      rel_q     <= rel_d;
      pressed_q <= pressed_d;
    end
  end

  assign sts_o.pressed_d = pressed_d;
  assign sts_o.hit = (ctl_i.clr_press & press_q) | (ctl_i.clr_release & rel_q);

endmodule

// File: rtl/dual_source_key_qualifier.sv
// top level of the dual source key qualifier: link merge and per-key qualification
// an item passes the input register, then the result register
// throughput: one item per cycle; both stages stall only on output back-pressure
// all key lanes update in parallel in the cycle the item leaves the input register
// reset: async active low; timers, events, link status, mouse and key state clear,
// press threshold returns to 6, both pipeline stages empty
module dual_source_key_qualifier import dsk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [TimerW-1:0] cfg_wdata_i
);

  // pipeline control
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance;
  in_t  in_q;
  out_t out_q;

  // threshold register
  logic [TimerW-1:0] thresh_q;

  // shared state shown on every result
  logic [1:0]              status_q, status_d;
  logic                    sec_q, sec_d;
  logic signed [AxisW-1:0] mx_q, mx_d, my_q, my_d, mz_q, mz_d;

  merge_t merge;
  logic   is_tick, is_clr_press, is_clr_release;

  lane_ctl_t [NumKeys-1:0] lane_ctl;
  lane_sts_t [NumKeys-1:0] lane_sts;
  logic [NumKeys-1:0]      pressed_all;
  logic [NumKeys-1:0]      hit_all;
  logic [BtnW-1:0]         pressed_out;

  // result stage takes a new item when empty or being drained
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_valid_d = (in_valid_i & in_ready_o) | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // command decode; the unused code does nothing
  always_comb begin
    is_tick        = 1'b0;
    is_clr_press   = 1'b0;
    is_clr_release = 1'b0;
    case (in_q.cmd)
      CmdTick:       is_tick        = advance;
      CmdClrPress:   is_clr_press   = advance;
      CmdClrRelease: is_clr_release = advance;
      default: ;
    endcase
  end

  dsk_link_merge u_merge (
    .item_i  (in_q),
    .merge_o (merge)
  );

  // link status and mouse follow only on ticks
  always_comb begin
    status_d = status_q;
    sec_d    = sec_q;
    mx_d     = mx_q;
    my_d     = my_q;
    mz_d     = mz_q;
    if (is_tick) begin
      status_d = merge.status;
      sec_d    = merge.sec_up;
      mx_d     = merge.x;
      my_d     = merge.y;
      mz_d     = merge.z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= LinkPrimary;
      sec_q    <= 1'b0;
      mx_q     <= '0;
      my_q     <= '0;
      mz_q     <= '0;
    end else begin
      status_q <= status_d;
      sec_q    <= sec_d;
      mx_q     <= mx_d;
      my_q     <= my_d;
      mz_q     <= mz_d;
    end
  end

  // one lane per key; keys past the button word are never down
  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    logic key_match;
    assign key_match = (32'(in_q.key_index) == k);

    if (k < BtnW) begin : g_btn
      assign lane_ctl[k].down = merge.buttons[k];
    end else begin : g_nobtn
      assign lane_ctl[k].down = 1'b0;
    end
    assign lane_ctl[k].tick        = is_tick;
    assign lane_ctl[k].clr_press   = is_clr_press & key_match;
    assign lane_ctl[k].clr_release = is_clr_release & key_match;

    dsk_key_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .threshold_i (thresh_q),
      .ctl_i       (lane_ctl[k]),
      .sts_o       (lane_sts[k])
    );

    assign pressed_all[k] = lane_sts[k].pressed_d;
    assign hit_all[k]     = lane_sts[k].hit;
  end

  // pressed word on the result is the button width wide
  for (genvar b = 0; b < BtnW; b++) begin : g_out
    if (b < NumKeys) begin : g_key
      assign pressed_out[b] = pressed_all[b];
    end else begin : g_none
      assign pressed_out[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.link_status       <= status_d;
      out_q.secondary_link_up <= sec_d;
      out_q.mouse_x           <= mx_d;
      out_q.mouse_y           <= my_d;
      out_q.mouse_z           <= mz_d;
      out_q.pressed_keys      <= pressed_out;
      out_q.any_pressed       <= |pressed_all;
      out_q.event_hit         <= |hit_all;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sim/tb_top.sv
// self-checking testbench of the dual source key qualifier: link merge and key events
module tb_top;
  import dsk_pkg::*;

  // command code outside the package set, must be ignored by the block
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned ReportLimit = 10;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [TimerW-1:0] cfg_wdata = '0;

  dual_source_key_qualifier dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // shadow copy of the key qualifier state
  logic [TimerW-1:0]  hold_timer_q [NumKeys];
  logic [NumKeys-1:0] confirmed_q;
  logic [NumKeys-1:0] press_ev_q;
  logic [NumKeys-1:0] release_ev_q;
  logic [BtnW-1:0]    pressed_q;
  link_e              link_q;
  logic               sec_up_q;
  logic [AxisW-1:0]   mouse_x_q, mouse_y_q, mouse_z_q;
  logic [TimerW-1:0]  threshold_q;

  out_t expected_results [$];

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned press_hits = 0;
  int unsigned release_hits = 0;

  // percentage of cycles each side sits idle, and a receiver hold-off in cycles
  int unsigned tx_idle_pct = 16;
  int unsigned rx_idle_pct = 16;
  int unsigned rx_hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic string fmt_result(out_t r);
    return $sformatf("link=%0d sec=%0b x=%0d y=%0d z=%0d keys=%05h any=%0b hit=%0b",
                     r.link_status, r.secondary_link_up, r.mouse_x, r.mouse_y,
                     r.mouse_z, r.pressed_keys, r.any_pressed, r.event_hit);
  endfunction

  // compare every accepted result against the oldest expectation
  initial begin
    out_t  want;
    string bad;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("unexpected result %0d: %s", results_seen, fmt_result(out_data));
        end else begin
          want = expected_results.pop_front();
          bad = "";
          if (out_data.link_status !== want.link_status) bad = {bad, " link_status"};
          if (out_data.secondary_link_up !== want.secondary_link_up)
            bad = {bad, " secondary_link_up"};
          if (out_data.mouse_x !== want.mouse_x) bad = {bad, " mouse_x"};
          if (out_data.mouse_y !== want.mouse_y) bad = {bad, " mouse_y"};
          if (out_data.mouse_z !== want.mouse_z) bad = {bad, " mouse_z"};
          if (out_data.pressed_keys !== want.pressed_keys) bad = {bad, " pressed_keys"};
          if (out_data.any_pressed !== want.any_pressed) bad = {bad, " any_pressed"};
          if (out_data.event_hit !== want.event_hit) bad = {bad, " event_hit"};
          if (bad != "") begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
              $display("result %0d mismatch in%s", results_seen, bad);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(out_data));
            end
          end
        end
      end
    end
  end

  task automatic clear_key_state();
    for (int k = 0; k < NumKeys; k++) hold_timer_q[k] = '0;
    confirmed_q = '0;
    press_ev_q = '0;
    release_ev_q = '0;
    pressed_q = '0;
    link_q = LinkPrimary;
    sec_up_q = 1'b0;
    mouse_x_q = '0;
    mouse_y_q = '0;
    mouse_z_q = '0;
    threshold_q = ThreshReset;
  endtask

  // advances the shadow state by one item and returns the result it produces
  function automatic out_t qualify_item(in_t it);
    out_t            res;
    logic [BtnW-1:0] merged;
    logic            hit;
    hit = 1'b0;
    if (it.cmd == CmdTick) begin
      ticks_sent++;
      // secondary buttons only count while the primary link is down
      merged = it.primary_up ? it.primary_buttons
                             : (it.primary_buttons | it.secondary_buttons);
      if (it.primary_up) link_q = LinkPrimary;
      else if (it.secondary_up) link_q = LinkSecondary;
      else link_q = LinkLost;
      sec_up_q = it.secondary_up;
      // per axis: primary wins while its link is up or its value is nonzero, else secondary
      mouse_x_q = (it.primary_up || it.primary_mouse_x != 0) ? it.primary_mouse_x
                                                             : it.secondary_mouse_x;
      mouse_y_q = (it.primary_up || it.primary_mouse_y != 0) ? it.primary_mouse_y
                                                             : it.secondary_mouse_y;
      mouse_z_q = (it.primary_up || it.primary_mouse_z != 0) ? it.primary_mouse_z
                                                             : it.secondary_mouse_z;
      for (int k = 0; k < NumKeys; k++) begin
        if (merged[k]) begin
          if (hold_timer_q[k] != TimerMax) hold_timer_q[k] = hold_timer_q[k] + 1'b1;
          // a saturated timer equal to the threshold re-latches every tick
          if (hold_timer_q[k] == threshold_q) begin
            press_ev_q[k] = 1'b1;
            confirmed_q[k] = 1'b1;
          end
        end else begin
          hold_timer_q[k] = '0;
          if (confirmed_q[k]) begin
            release_ev_q[k] = 1'b1;
            confirmed_q[k] = 1'b0;
          end
        end
      end
      pressed_q = merged;
    end else if (it.cmd == CmdClrPress && it.key_index < NumKeys) begin
      hit = press_ev_q[it.key_index];
      press_ev_q[it.key_index] = 1'b0;
      if (hit) press_hits++;
    end else if (it.cmd == CmdClrRelease && it.key_index < NumKeys) begin
      hit = release_ev_q[it.key_index];
      release_ev_q[it.key_index] = 1'b0;
      if (hit) release_hits++;
    end
    res.link_status = link_q;
    res.secondary_link_up = sec_up_q;
    res.mouse_x = mouse_x_q;
    res.mouse_y = mouse_y_q;
    res.mouse_z = mouse_z_q;
    res.pressed_keys = pressed_q;
    res.any_pressed = |pressed_q;
    res.event_hit = hit;
    return res;
  endfunction

  // offers one item, idling first at random; valid stays up after the handshake
  task automatic send_item(in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(qualify_item(it));
    items_sent++;
  endtask

  // drops valid and waits until every expected result has come back
  task automatic finish_burst();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [TimerW-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_q = value;
  endtask

  function automatic logic [AxisW-1:0] pick_axis();
    case ($urandom_range(15))
      0, 1, 2, 3: return '0;
      4:          return 16'h8000;
      5:          return 16'h7FFF;
      default:    return AxisW'($urandom());
    endcase
  endfunction

  function automatic in_t random_payload();
    in_t it;
    it.cmd = 2'($urandom_range(3));
    it.key_index = 5'($urandom_range(31));
    it.primary_up = 1'($urandom_range(1));
    it.secondary_up = 1'($urandom_range(1));
    it.primary_mouse_x = pick_axis();
    it.primary_mouse_y = pick_axis();
    it.primary_mouse_z = pick_axis();
    it.primary_buttons = BtnW'($urandom());
    it.secondary_mouse_x = pick_axis();
    it.secondary_mouse_y = pick_axis();
    it.secondary_mouse_z = pick_axis();
    it.secondary_buttons = BtnW'($urandom());
    return it;
  endfunction

  // update tick carrying the held key set, split over the links when primary is down
  function automatic in_t random_tick(logic [BtnW-1:0] held, logic p_up, logic s_up);
    in_t             it;
    logic [BtnW-1:0] split;
    it = random_payload();
    split = BtnW'($urandom());
    it.cmd = CmdTick;
    it.primary_up = p_up;
    it.secondary_up = s_up;
    if ($urandom_range(9) == 0) begin
      // noisy buttons on top of the held set
      it.primary_buttons = it.primary_buttons | held;
    end else if (p_up) begin
      it.primary_buttons = held;
    end else begin
      it.primary_buttons = held & split;
      it.secondary_buttons = (held & ~split) | (held & BtnW'($urandom()));
    end
    return it;
  endfunction

  function automatic in_t random_query();
    in_t         it;
    int unsigned r;
    it = random_payload();
    r = $urandom_range(99);
    if (r < 46) it.cmd = CmdClrPress;
    else if (r < 92) it.cmd = CmdClrRelease;
    else it.cmd = CmdUnused;
    if ($urandom_range(99) < 88) it.key_index = 5'($urandom_range(NumKeys - 1));
    else it.key_index = 5'($urandom_range(31, NumKeys));
    return it;
  endfunction

  // each bit set with probability 2^-n
  function automatic logic [BtnW-1:0] sparse_bits(int unsigned n);
    logic [BtnW-1:0] m;
    m = '1;
    repeat (n) m &= BtnW'($urandom());
    return m;
  endfunction

  // key sets held over several ticks so that timers reach the threshold
  task automatic run_phase(int unsigned n_items, int unsigned tick_pct,
                           int unsigned sparsity, logic [BtnW-1:0] pinned);
    logic [BtnW-1:0] held;
    logic            p_up;
    logic            s_up;
    held = pinned;
    p_up = 1'($urandom_range(1));
    s_up = 1'($urandom_range(1));
    repeat (n_items) begin
      if ($urandom_range(99) < tick_pct) begin
        held = (held ^ sparse_bits(sparsity)) | pinned;
        if ($urandom_range(24) == 0) p_up = ~p_up;
        if ($urandom_range(7) == 0) s_up = ~s_up;
        send_item(random_tick(held, p_up, s_up));
      end else begin
        send_item(random_query());
      end
    end
    finish_burst();
  endtask

  function automatic in_t make_tick(logic p_up, logic s_up,
                                    logic [AxisW-1:0] px, logic [AxisW-1:0] py,
                                    logic [AxisW-1:0] pz, logic [BtnW-1:0] pb,
                                    logic [AxisW-1:0] sx, logic [AxisW-1:0] sy,
                                    logic [AxisW-1:0] sz, logic [BtnW-1:0] sb);
    in_t it;
    it.cmd = CmdTick;
    it.key_index = '0;
    it.primary_up = p_up;
    it.secondary_up = s_up;
    it.primary_mouse_x = px;
    it.primary_mouse_y = py;
    it.primary_mouse_z = pz;
    it.primary_buttons = pb;
    it.secondary_mouse_x = sx;
    it.secondary_mouse_y = sy;
    it.secondary_mouse_z = sz;
    it.secondary_buttons = sb;
    return it;
  endfunction

  function automatic in_t make_query(logic [1:0] cmd, logic [4:0] key);
    in_t it;
    it = random_payload();
    it.cmd = cmd;
    it.key_index = key;
    return it;
  endfunction

  // link status and mouse/button merge across the primary and secondary links
  task automatic test_link_merge();
    send_item(make_query(CmdClrPress, 5'd0));
    send_item(make_tick(1'b1, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, '1,
                        16'h1234, 16'h8000, 16'h0001, 18'h0AAAA));
    // primary up: zero primary axes still win, secondary axes and buttons stay unused
    send_item(make_tick(1'b1, 1'b0, 16'h0000, 16'h8000, 16'h0000, '0,
                        16'h7FFF, 16'h7FFF, 16'h8000, '1));
    send_item(make_tick(1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 18'h00F0F,
                        16'h8000, 16'h7FFF, 16'hFFFF, 18'h30300));
    send_item(make_tick(1'b0, 1'b0, 16'h8000, 16'h0000, 16'h0005, 18'h00001,
                        16'h4321, 16'h7FFF, 16'h1111, 18'h20000));
    // secondary link down yet its data still merged
    send_item(make_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, '0,
                        16'hFFFF, 16'h8000, 16'h7FFF, '1));
    send_item(make_query(CmdUnused, 5'd3));
    finish_burst();
  endtask

  // press confirmation at the reset threshold, release events, odd queries
  task automatic test_key_events();
    in_t hold;
    hold = make_tick(1'b1, 1'b0, 16'h0001, 16'h0002, 16'h0003, 18'h20001,
                     '0, '0, '0, '0);
    repeat (ThreshReset) send_item(hold);
    send_item(make_query(CmdClrPress, 5'd0));
    send_item(make_query(CmdClrPress, 5'd0));
    send_item(make_query(CmdClrPress, 5'd17));
    send_item(make_query(CmdClrRelease, 5'd0));
    send_item(make_tick(1'b1, 1'b1, '0, '0, '0, '0, '0, '0, '0, '1));
    send_item(make_query(CmdClrRelease, 5'd17));
    send_item(make_query(CmdClrRelease, 5'd0));
    send_item(make_query(CmdClrPress, 5'd18));
    send_item(make_query(CmdClrRelease, 5'd31));
    send_item(make_query(CmdUnused, 5'd0));
    finish_burst();
  endtask

  // lowest, highest, zero and mid thresholds with matching hold patterns
  task automatic test_threshold_sweep();
    logic [BtnW-1:0] pinned;
    write_threshold(8'd1);
    run_phase(200, 60, 3, '0);
    write_threshold(TimerW'($urandom_range(2, 12)));
    run_phase(250, 65, 3, '0);
    // some keys pinned long enough to saturate their timers
    pinned = (BtnW'(1) << $urandom_range(BtnW - 1)) | (BtnW'(1) << $urandom_range(BtnW - 1))
           | (BtnW'(1) << $urandom_range(BtnW - 1));
    write_threshold(TimerMax);
    run_phase(420, 90, 6, pinned);
    write_threshold(8'd0);
    run_phase(120, 65, 3, '0);
  endtask

  // the receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    write_threshold(ThreshReset);
    tx_idle_pct = 0;
    rx_hold_left = 300;
    run_phase(80, 70, 3, '0);
    tx_idle_pct = 16;
  endtask

  // back-to-back items with no idling on either side
  task automatic test_steady_stream();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(250, 65, 3, '0);
    tx_idle_pct = 16;
    rx_idle_pct = 16;
  endtask

  task automatic test_random_mix();
    repeat (3) begin
      if ($urandom_range(1)) write_threshold(TimerW'($urandom_range(1, 255)));
      else write_threshold(TimerW'($urandom_range(2, 8)));
      run_phase(100, 65, 3, '0);
    end
  endtask

  initial begin
    clear_key_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_link_merge();
    test_key_events();
    test_threshold_sweep();
    test_backpressure();
    test_steady_stream();
    test_random_mix();

    finish_burst();
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() != 0) fail_count++;

    $display("ran %0d items (%0d update ticks) in %0d cycles, %0d results checked",
             items_sent, ticks_sent, cycle_count, results_seen);
    $display("thresholds 0, 1, reset, 255 and random; %0d press and %0d release events read",
             press_hits, release_hits);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/dsk_pkg.sv
rtl/dsk_link_merge.sv
rtl/dsk_key_lane.sv
rtl/dual_source_key_qualifier.sv
sim/tb_top.sv
